@@ rtl/arbw_pkg.sv @@
// Shared types and constants for the alpha recovery block.
`timescale 1ns / 1ps

package arbw_pkg;

	localparam int unsigned PIX_W = 32;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned RATIO_W = 16;
	localparam int unsigned LANES = 3;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned DIV_STEPS = RATIO_W;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);

	localparam logic [CHAN_W-1:0] ALPHA_ONE = 8'hFF;
	localparam logic [PIX_W-1:0] EMPTY_FIRST = {ALPHA_ONE, 24'h000000};

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic summary;
		logic uni_alpha;
		logic uni_color;
		logic [PIX_W-1:0] first;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} back_state_t;

endpackage

@@ rtl/arbw_front.sv @@
// Front end: recovers alpha, tracks the frame and classifies each item.
`timescale 1ns / 1ps

module arbw_front (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic [arbw_pkg::PIX_W-1:0] black_pixel,
	input  logic [arbw_pkg::PIX_W-1:0] white_pixel,
	input  logic last_pixel,
	input  logic empty_frame,
	output arbw_pkg::entry_t entry
);

	logic [arbw_pkg::PIX_W-1:0] first_q;
	logic [arbw_pkg::PIX_W-1:0] delta_q;
	logic in_frame_q;

	logic [arbw_pkg::CHAN_W-1:0] alpha;
	logic [arbw_pkg::PIX_W-1:0] pix;
	logic [arbw_pkg::PIX_W-1:0] first_sel;
	logic [arbw_pkg::PIX_W-1:0] delta_new;
	logic uni_alpha;

	always_comb begin
		alpha = arbw_pkg::ALPHA_ONE - white_pixel[15:8] + black_pixel[15:8];
		pix = {alpha, black_pixel[23:0]};
		first_sel = in_frame_q ? first_q : pix;
		delta_new = (in_frame_q ? delta_q : '0) | (first_sel ^ pix);
		uni_alpha = (delta_new[31:24] == '0);

		entry = '0;
		if (empty_frame) begin
			entry.summary = 1'b1;
			entry.uni_alpha = 1'b1;
			entry.uni_color = 1'b1;
			entry.first = arbw_pkg::EMPTY_FIRST;
		end else begin
			entry.pixel = pix;
			if (last_pixel) begin
				entry.summary = 1'b1;
				entry.uni_alpha = uni_alpha;
				entry.uni_color = uni_alpha && (delta_new[23:0] == '0);
				entry.first = first_sel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			delta_q <= '0;
			in_frame_q <= 1'b0;
		end else if (accept) begin
			if (empty_frame) begin
				first_q <= '0;
				delta_q <= '0;
				in_frame_q <= 1'b0;
			end else if (last_pixel) begin
				first_q <= first_sel;
				delta_q <= '0;
				in_frame_q <= 1'b0;
			end else begin
				first_q <= first_sel;
				delta_q <= delta_new;
				in_frame_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/arbw_queue.sv @@
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps

module arbw_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  arbw_pkg::entry_t push_entry,
	input  logic pop,
	output arbw_pkg::entry_t head,
	output logic full,
	output logic empty
);

	arbw_pkg::entry_t store_q [arbw_pkg::QDEPTH];
	logic [arbw_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [arbw_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [arbw_pkg::QCNT_W-1:0] count_q;

	assign full = (count_q == arbw_pkg::QCNT_W'(arbw_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("Queue written while full.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("Queue read while empty.");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= arbw_pkg::QCNT_W'(arbw_pkg::QDEPTH)) else $error("Queue count out of range.");

endmodule

@@ rtl/arbw_back.sv @@
// Back end: divides the summary channels by alpha and holds the result item.
`timescale 1ns / 1ps

module arbw_back (
	input  logic clk,
	input  logic arst_n,
	input  arbw_pkg::entry_t head,
	input  logic q_empty,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [arbw_pkg::PIX_W-1:0] out_pixel,
	output logic summary_valid,
	output logic uniform_alpha,
	output logic uniform_color,
	output logic [arbw_pkg::CHAN_W-1:0] alpha_code,
	output logic [arbw_pkg::RATIO_W-1:0] chan_low_ratio,
	output logic [arbw_pkg::RATIO_W-1:0] chan_mid_ratio,
	output logic [arbw_pkg::RATIO_W-1:0] chan_high_ratio
);

	arbw_pkg::back_state_t state_q;
	logic [arbw_pkg::CNT_W-1:0] cnt_q;
	logic [arbw_pkg::CHAN_W-1:0] rem_q [arbw_pkg::LANES];
	logic [arbw_pkg::RATIO_W-1:0] dq_q [arbw_pkg::LANES];
	logic out_valid_q;

	logic [arbw_pkg::CHAN_W-1:0] rem_nxt [arbw_pkg::LANES];
	logic [arbw_pkg::RATIO_W-1:0] dq_nxt [arbw_pkg::LANES];
	logic [arbw_pkg::CHAN_W:0] trial;
	logic [arbw_pkg::CHAN_W-1:0] divisor;
	logic out_free;
	logic need_div;
	logic load_plain;
	logic load_ratio;
	logic last_step;

	assign divisor = head.first[31:24];
	assign out_free = !out_valid_q || out_ready;
	assign need_div = head.summary && (divisor != '0);
	assign load_plain = (state_q == arbw_pkg::ST_IDLE) && !q_empty && !need_div && out_free;
	assign load_ratio = (state_q == arbw_pkg::ST_FIN) && out_free;
	assign pop = load_plain || load_ratio;
	assign last_step = (cnt_q == arbw_pkg::CNT_W'(arbw_pkg::DIV_STEPS - 1));
	assign out_valid = out_valid_q;

	// One restoring division step per lane and cycle.
	always_comb begin
		for (int i = 0; i < arbw_pkg::LANES; i++) begin
			trial = {rem_q[i], dq_q[i][arbw_pkg::RATIO_W-1]};
			if (trial >= {1'b0, divisor}) begin
				rem_nxt[i] = arbw_pkg::CHAN_W'(trial - {1'b0, divisor});
				dq_nxt[i] = {dq_q[i][arbw_pkg::RATIO_W-2:0], 1'b1};
			end else begin
				rem_nxt[i] = trial[arbw_pkg::CHAN_W-1:0];
				dq_nxt[i] = {dq_q[i][arbw_pkg::RATIO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arbw_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				arbw_pkg::ST_IDLE: begin
					if (!q_empty && need_div) begin
						state_q <= arbw_pkg::ST_DIV;
						cnt_q <= '0;
					end
				end
				arbw_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= arbw_pkg::ST_FIN;
					end
				end
				arbw_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= arbw_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= arbw_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == arbw_pkg::ST_IDLE) begin
			for (int i = 0; i < arbw_pkg::LANES; i++) begin
				rem_q[i] <= '0;
				dq_q[i] <= {head.first[i*arbw_pkg::CHAN_W +: arbw_pkg::CHAN_W],
					arbw_pkg::CHAN_W'(0)};
			end
		end else if (state_q == arbw_pkg::ST_DIV) begin
			for (int i = 0; i < arbw_pkg::LANES; i++) begin
				rem_q[i] <= rem_nxt[i];
				dq_q[i] <= dq_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_pixel <= head.pixel;
			summary_valid <= head.summary;
			uniform_alpha <= head.uni_alpha;
			uniform_color <= head.uni_color;
			alpha_code <= divisor;
			chan_low_ratio <= load_ratio ? dq_q[0] : '0;
			chan_mid_ratio <= load_ratio ? dq_q[1] : '0;
			chan_high_ratio <= load_ratio ? dq_q[2] : '0;
		end
	end

	a_fin_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != arbw_pkg::ST_IDLE) |-> (!q_empty && need_div))
		else $error("Division running without a summary item at the queue head.");
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arbw_pkg::ST_DIV && last_step) |=> (state_q == arbw_pkg::ST_FIN))
		else $error("Division did not finish after its last step.");
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> out_free) else $error("Output register overwritten while held.");

endmodule

@@ rtl/alpha_recovery_black_white.sv @@
// Top level of the alpha recovery block for black and white renders.
// An accepted item is written into the queue and loaded into the output register when the
// back end pops it; the result item is held there until m_tready takes it.
// Throughput: one pixel item per cycle while the queue has room; a summary item with a nonzero
// alpha code (empty frames included) holds the back end while the 16-step divider runs.
// Reset (arst_n low) empties the queue, drops the output item and closes any open frame.
`timescale 1ns / 1ps

module alpha_recovery_black_white (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,	// black_pixel, white_pixel
	input  logic s_tlast,
	input  logic s_tuser,	// empty_frame
	output logic m_tvalid,
	input  logic m_tready,
	// out_pixel, uniform_alpha, uniform_color, alpha_code, chan_low_ratio,
	// chan_mid_ratio, chan_high_ratio, zero fill
	output logic [95:0] m_tdata,
	output logic m_tuser	// summary_valid
);

	arbw_pkg::entry_t push_entry;
	arbw_pkg::entry_t head;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic accept;

	logic [arbw_pkg::PIX_W-1:0] out_pixel;
	logic uniform_alpha;
	logic uniform_color;
	logic [arbw_pkg::CHAN_W-1:0] alpha_code;
	logic [arbw_pkg::RATIO_W-1:0] chan_low_ratio;
	logic [arbw_pkg::RATIO_W-1:0] chan_mid_ratio;
	logic [arbw_pkg::RATIO_W-1:0] chan_high_ratio;

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	arbw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.black_pixel(s_tdata[31:0]),
		.white_pixel(s_tdata[63:32]),
		.last_pixel(s_tlast),
		.empty_frame(s_tuser),
		.entry(push_entry)
	);

	arbw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_entry(push_entry),
		.pop(q_pop),
		.head(head),
		.full(q_full),
		.empty(q_empty)
	);

	arbw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_empty(q_empty),
		.pop(q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_pixel(out_pixel),
		.summary_valid(m_tuser),
		.uniform_alpha(uniform_alpha),
		.uniform_color(uniform_color),
		.alpha_code(alpha_code),
		.chan_low_ratio(chan_low_ratio),
		.chan_mid_ratio(chan_mid_ratio),
		.chan_high_ratio(chan_high_ratio)
	);

	assign m_tdata = {6'b000000, chan_high_ratio, chan_mid_ratio, chan_low_ratio,
		alpha_code, uniform_color, uniform_alpha, out_pixel};

endmodule
